// ----- src/bnc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket name checker package
// Length limits, forbidden prefixes and suffixes, and the character class
// bundle shared by the checker modules.
// ----------------------------------------------------------------------------
package bnc_pkg;

    localparam int MIN_LENGTH = 3;
    localparam int MAX_LENGTH = 63;

    // The counter stops one above the longest legal name.
    localparam int CNT_W = $clog2(MAX_LENGTH + 2);

    localparam int LEAD_BYTES   = 7;
    localparam int RECENT_BYTES = 8;

    typedef logic [7:0]       char_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam int PFX_XN_LEN    = 4;
    localparam int PFX_THREE_LEN = 7;
    localparam int SFX_ALIAS_LEN = 8;
    localparam int SFX_OL_LEN    = 7;

    localparam char_t PFX_XN    [PFX_XN_LEN]    = '{"x", "n", "-", "-"};
    localparam char_t PFX_THREE [PFX_THREE_LEN] = '{"s", "t", "h", "r", "e", "e", "-"};
    localparam char_t SFX_ALIAS [SFX_ALIAS_LEN] = '{"-", "s", "3", "a", "l", "i", "a", "s"};
    localparam char_t SFX_OL    [SFX_OL_LEN]    = '{"-", "-", "o", "l", "-", "s", "3"};

    typedef struct packed {
        logic is_digit;
        logic is_alnum;
        logic is_sep;
        logic is_dot;
    } char_class_t;

endpackage
`default_nettype wire

// ----- src/bnc_char_class.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Character classifier
// Sorts one name byte into digit, lowercase letter or digit, separator and dot.
// ----------------------------------------------------------------------------
module bnc_char_class
    import bnc_pkg::*;
(
    input  wire char_t       name_char,
    output char_class_t      cls
);

    logic digit;
    logic lower;

    assign digit = (name_char >= "0") && (name_char <= "9");
    assign lower = (name_char >= "a") && (name_char <= "z");

    assign cls.is_digit = digit;
    assign cls.is_alnum = digit | lower;
    assign cls.is_dot   = (name_char == ".");
    assign cls.is_sep   = (name_char == ".") || (name_char == "-");

endmodule
`default_nettype wire

// ----- src/bnc_name_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Name tracker
// Holds the running state of the name being checked and forms the verdict
// for the byte presented, as if that byte were the last.
// ----------------------------------------------------------------------------
module bnc_name_tracker
    import bnc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         advance,
    input  wire char_t  name_char,
    input  wire         last_char,
    input  wire char_class_t cls,
    output logic        name_valid
);

    count_t     count_reg,     count_next;
    char_t      lead_reg   [LEAD_BYTES];
    char_t      lead_next  [LEAD_BYTES];
    char_t      recent_reg [RECENT_BYTES];
    char_t      recent_next[RECENT_BYTES];
    logic       chars_ok_reg,  chars_ok_next;
    logic       prev_sep_reg;
    logic [1:0] groups_reg,    groups_next;
    logic [1:0] digits_reg,    digits_next;
    logic       quad_ok_reg,   quad_ok_next;

    logic pfx_xn_hit, pfx_three_hit, sfx_alias_hit, sfx_ol_hit;
    logic len_ok, is_quad;

    always_comb
    begin
        chars_ok_next = chars_ok_reg;
        if (!cls.is_alnum && !cls.is_sep)
        begin
            chars_ok_next = 1'b0;
        end
        if ((count_reg == '0) && !cls.is_alnum)
        begin
            chars_ok_next = 1'b0;
        end
        if (cls.is_sep && prev_sep_reg)
        begin
            chars_ok_next = 1'b0;
        end

        groups_next  = groups_reg;
        digits_next  = digits_reg;
        quad_ok_next = quad_ok_reg;
        if (cls.is_digit)
        begin
            if (digits_reg == 2'd3)
            begin
                quad_ok_next = 1'b0;
            end
            else
            begin
                digits_next = digits_reg + 2'd1;
            end
        end
        else if (cls.is_dot)
        begin
            if ((digits_reg == 2'd0) || (groups_reg == 2'd3))
            begin
                quad_ok_next = 1'b0;
            end
            else
            begin
                groups_next = groups_reg + 2'd1;
                digits_next = 2'd0;
            end
        end
        else
        begin
            quad_ok_next = 1'b0;
        end

        for (int i = 0; i < LEAD_BYTES; i++)
        begin
            lead_next[i] = (count_reg == CNT_W'(i)) ? name_char : lead_reg[i];
        end

        recent_next[0] = name_char;
        for (int k = 1; k < RECENT_BYTES; k++)
        begin
            recent_next[k] = recent_reg[k-1];
        end

        if (count_reg < CNT_W'(MAX_LENGTH + 1))
        begin
            count_next = count_reg + count_t'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        pfx_xn_hit    = (count_next >= CNT_W'(PFX_XN_LEN));
        pfx_three_hit = (count_next >= CNT_W'(PFX_THREE_LEN));
        sfx_alias_hit = (count_next >= CNT_W'(SFX_ALIAS_LEN));
        sfx_ol_hit    = (count_next >= CNT_W'(SFX_OL_LEN));
        for (int i = 0; i < PFX_XN_LEN; i++)
        begin
            if (lead_next[i] != PFX_XN[i]) pfx_xn_hit = 1'b0;
        end
        for (int i = 0; i < PFX_THREE_LEN; i++)
        begin
            if (lead_next[i] != PFX_THREE[i]) pfx_three_hit = 1'b0;
        end
        for (int k = 0; k < SFX_ALIAS_LEN; k++)
        begin
            if (recent_next[k] != SFX_ALIAS[SFX_ALIAS_LEN-1-k]) sfx_alias_hit = 1'b0;
        end
        for (int k = 0; k < SFX_OL_LEN; k++)
        begin
            if (recent_next[k] != SFX_OL[SFX_OL_LEN-1-k]) sfx_ol_hit = 1'b0;
        end
    end

    assign len_ok  = (count_next >= CNT_W'(MIN_LENGTH)) && (count_next <= CNT_W'(MAX_LENGTH));
    assign is_quad = quad_ok_next && (groups_next == 2'd3) && (digits_next != 2'd0);

    assign name_valid = chars_ok_next && cls.is_alnum && len_ok
                     && !pfx_xn_hit && !pfx_three_hit
                     && !sfx_alias_hit && !sfx_ol_hit && !is_quad;

    // The whole state returns to its starting values after the closing byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            chars_ok_reg <= 1'b1;
            prev_sep_reg <= 1'b0;
            groups_reg   <= 2'd0;
            digits_reg   <= 2'd0;
            quad_ok_reg  <= 1'b1;
            for (int i = 0; i < LEAD_BYTES; i++) lead_reg[i] <= '0;
            for (int k = 0; k < RECENT_BYTES; k++) recent_reg[k] <= '0;
        end
        else if (advance)
        begin
            if (last_char)
            begin
                count_reg    <= '0;
                chars_ok_reg <= 1'b1;
                prev_sep_reg <= 1'b0;
                groups_reg   <= 2'd0;
                digits_reg   <= 2'd0;
                quad_ok_reg  <= 1'b1;
                for (int i = 0; i < LEAD_BYTES; i++) lead_reg[i] <= '0;
                for (int k = 0; k < RECENT_BYTES; k++) recent_reg[k] <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                chars_ok_reg <= chars_ok_next;
                prev_sep_reg <= cls.is_sep;
                groups_reg   <= groups_next;
                digits_reg   <= digits_next;
                quad_ok_reg  <= quad_ok_next;
                lead_reg     <= lead_next;
                recent_reg   <= recent_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/bucket_name_checker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket name checker, top level
// Streams the bytes of a storage bucket name and returns one verdict per name.
// ----------------------------------------------------------------------------
// The name arrives one byte per transfer on the input channel, with last_char
// set on the closing byte, and one verdict transfer follows each closing byte
// and nothing else. Each byte is captured in an input register, and from
// there the classifier and the name tracker update the running state and,
// on the closing byte, load the verdict into a result register, so a new
// byte can be taken in every cycle unless a closing byte is held. The only
// thing that holds the input back is a closing byte meeting a verdict that
// the consumer has not yet taken; ordinary bytes never wait. There is no
// configuration and no start-up pass: the block is ready straight after
// reset, and the tracker starts afresh after every closing byte.
// ----------------------------------------------------------------------------
module bucket_name_checker_top
    import bnc_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  name_char,
    input  wire         last_char,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        name_valid
);

    // Input register stage.
    logic   s1_valid_reg;
    char_t  s1_char_reg;
    logic   s1_last_reg;

    // Result register.
    logic   out_valid_reg;
    logic   name_valid_reg;

    char_class_t cls;
    logic        verdict;
    logic        slot_free;
    logic        s1_advance;

    // The result slot can take a verdict when empty or when its verdict leaves now.
    assign slot_free  = !out_valid_reg || out_ready;
    // A byte in the input stage moves on unless it is a closing byte with nowhere to go.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || slot_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign out_valid  = out_valid_reg;
    assign name_valid = name_valid_reg;

    bnc_char_class u_class
    (
        .name_char (s1_char_reg),
        .cls       (cls)
    );

    bnc_name_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_advance),
        .name_char  (s1_char_reg),
        .last_char  (s1_last_reg),
        .cls        (cls),
        .name_valid (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= name_char;
            s1_last_reg <= last_char;
        end
        if (s1_advance && s1_last_reg)
        begin
            name_valid_reg <= verdict;
        end
    end

    // An ordinary byte in the input stage never stalls the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |-> in_ready)
        else $error("input stalled on an ordinary byte");

    // A closing byte facing an untaken verdict must hold the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while a verdict is blocked");

    // A verdict appears only after a closing byte sat in the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("verdict without a closing byte");

endmodule
`default_nettype wire
